// ===== hw/rtl/particle_box_collision_step_assert.svh =====
// ----------------------------------------------------------------------------
// Particle box collision step: assertion macros
// Concurrent assertion forms used by the wall stage.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_BOX_COLLISION_STEP_ASSERT_SVH
`define PARTICLE_BOX_COLLISION_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBCS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pbcs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBCS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pbcs: next-cycle check failed");

`endif

// ===== hw/rtl/pbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle box collision step: package
// Types, constants and saturation helper shared by all pipeline stages.
// ----------------------------------------------------------------------------
package pbcs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PROD_SHIFT = 16;
    localparam int TOL_LSB    = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int DAMP_Q16   = 58982;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_CENTER_X    = 3'd0,
        CFG_BOX_CENTER_Y    = 3'd1,
        CFG_BOX_CENTER_Z    = 3'd2,
        CFG_HALF_EXTENT_X   = 3'd3,
        CFG_HALF_EXTENT_Y   = 3'd4,
        CFG_HALF_EXTENT_Z   = 3'd5,
        CFG_PARTICLE_RADIUS = 3'd6,
        CFG_RESTITUTION     = 3'd7
    } pbcs_cfg_idx_t;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [33:0] bound_t;

    typedef struct packed {
        q16_t        pos_x;
        q16_t        pos_y;
        q16_t        pos_z;
        q16_t        vel_x;
        q16_t        vel_y;
        q16_t        vel_z;
        logic [15:0] time_step;
    } pbcs_in_t;

    typedef struct packed {
        q16_t new_pos_x;
        q16_t new_pos_y;
        q16_t new_pos_z;
        q16_t new_vel_x;
        q16_t new_vel_y;
        q16_t new_vel_z;
        logic needs_update;
    } pbcs_out_t;

    // Box limits already shifted by the particle radius, plus negated restitution.
    typedef struct packed {
        bound_t [NUM_AXES-1:0] lo_in;
        bound_t [NUM_AXES-1:0] hi_in;
        logic signed [17:0]    neg_rest;
    } pbcs_cfg_t;

    typedef struct packed {
        q16_t [NUM_AXES-1:0]        prev;
        q16_t [NUM_AXES-1:0]        vel;
        logic [NUM_AXES-1:0][48:0]  prod_dt;
    } pbcs_s1_t;

    typedef struct packed {
        q16_t [NUM_AXES-1:0]        pos;
        q16_t [NUM_AXES-1:0]        prev;
        q16_t [NUM_AXES-1:0]        vel;
        logic [NUM_AXES-1:0][49:0]  prod_vr;
    } pbcs_s2_t;

    typedef struct packed {
        q16_t [NUM_AXES-1:0] pos;
        q16_t [NUM_AXES-1:0] prev;
        q16_t [NUM_AXES-1:0] vel;
        logic                hit_any;
        logic                floor_hit;
    } pbcs_s3_t;

    localparam bound_t SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam bound_t SAT_MIN = -34'sh0_8000_0000;

    function automatic q16_t sat32(input bound_t v);
        q16_t r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pbcs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Particle box collision step: configuration registers
// Holds the box, radius and restitution and precomputes the clamp limits.
// ----------------------------------------------------------------------------
module pbcs_cfg_regs import pbcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output pbcs_cfg_t             cfg
);

    q16_t [NUM_AXES-1:0]        center_reg;
    logic [NUM_AXES-1:0][30:0]  half_reg;
    logic [30:0]                radius_reg;
    logic [16:0]                rest_reg;
    pbcs_cfg_t                  cfg_reg;
    pbcs_cfg_t                  cfg_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            half_reg[0] <= 31'd6553600;
            half_reg[1] <= 31'd13107200;
            half_reg[2] <= 31'd13107200;
            radius_reg  <= 31'd655360;
            rest_reg    <= 17'd52429;
        end else if (cfg_we) begin
            unique case (pbcs_cfg_idx_t'(cfg_index))
                CFG_BOX_CENTER_X:    center_reg[0] <= cfg_wdata;
                CFG_BOX_CENTER_Y:    center_reg[1] <= cfg_wdata;
                CFG_BOX_CENTER_Z:    center_reg[2] <= cfg_wdata;
                CFG_HALF_EXTENT_X:   half_reg[0]   <= cfg_wdata[30:0];
                CFG_HALF_EXTENT_Y:   half_reg[1]   <= cfg_wdata[30:0];
                CFG_HALF_EXTENT_Z:   half_reg[2]   <= cfg_wdata[30:0];
                CFG_PARTICLE_RADIUS: radius_reg    <= cfg_wdata[30:0];
                CFG_RESTITUTION:     rest_reg      <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            cfg_next.lo_in[i] = $signed({{2{center_reg[i][31]}}, center_reg[i]})
                              - $signed({3'b000, half_reg[i]})
                              + $signed({3'b000, radius_reg});
            cfg_next.hi_in[i] = $signed({{2{center_reg[i][31]}}, center_reg[i]})
                              + $signed({3'b000, half_reg[i]})
                              - $signed({3'b000, radius_reg});
        end
        cfg_next.neg_rest = 18'sd0 - $signed({1'b0, rest_reg});
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/pbcs_integrate.sv =====
// ----------------------------------------------------------------------------
// Particle box collision step: integration stages
// Forms velocity times time step, then adds it to the position with saturation.
// ----------------------------------------------------------------------------
module pbcs_integrate import pbcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  pbcs_in_t  in_data,
    input  pbcs_cfg_t cfg,
    output logic      out_valid,
    output pbcs_s2_t  out_data
);

    q16_t [NUM_AXES-1:0] in_pos;
    q16_t [NUM_AXES-1:0] in_vel;
    logic                s1_valid_reg;
    pbcs_s1_t            s1_reg;
    pbcs_s1_t            s1_next;
    logic                s2_valid_reg;
    pbcs_s2_t            s2_reg;
    pbcs_s2_t            s2_next;

    assign in_pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    assign in_vel = {in_data.vel_z, in_data.vel_y, in_data.vel_x};

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            s1_next.prev[i]    = in_pos[i];
            s1_next.vel[i]     = in_vel[i];
            s1_next.prod_dt[i] = $signed(in_vel[i]) * $signed({1'b0, in_data.time_step});
        end
    end

    always_comb begin
        logic signed [48:0] sh;
        logic signed [33:0] sum;
        sh  = '0;
        sum = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            sh  = $signed(s1_reg.prod_dt[i]) >>> PROD_SHIFT;
            sum = $signed({{2{s1_reg.prev[i][31]}}, s1_reg.prev[i]}) + $signed(sh[33:0]);
            s2_next.pos[i]     = sat32(sum);
            s2_next.prev[i]    = s1_reg.prev[i];
            s2_next.vel[i]     = s1_reg.vel[i];
            s2_next.prod_vr[i] = $signed(s1_reg.vel[i]) * cfg.neg_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

// ===== hw/rtl/pbcs_wall.sv =====
// ----------------------------------------------------------------------------
// Particle box collision step: wall stage
// Tests each axis against the box walls, clamps and reflects the velocity.
// ----------------------------------------------------------------------------
module pbcs_wall import pbcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  pbcs_s2_t  in_data,
    input  pbcs_cfg_t cfg,
    output logic      out_valid,
    output pbcs_s3_t  out_data
);

    logic [NUM_AXES-1:0] below;
    logic [NUM_AXES-1:0] above;
    logic                s3_valid_reg;
    pbcs_s3_t            s3_reg;
    pbcs_s3_t            s3_next;

    always_comb begin
        logic signed [33:0] p_ext;
        logic signed [49:0] vr_sh;
        p_ext = '0;
        vr_sh = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            p_ext    = $signed({{2{in_data.pos[i][31]}}, in_data.pos[i]});
            below[i] = p_ext < $signed(cfg.lo_in[i]);
            above[i] = !below[i] && (p_ext > $signed(cfg.hi_in[i]));
            vr_sh    = $signed(in_data.prod_vr[i]) >>> PROD_SHIFT;
            if (below[i]) begin
                s3_next.pos[i] = sat32(cfg.lo_in[i]);
            end else if (above[i]) begin
                s3_next.pos[i] = sat32(cfg.hi_in[i]);
            end else begin
                s3_next.pos[i] = in_data.pos[i];
            end
            s3_next.vel[i]  = (below[i] || above[i]) ? sat32(vr_sh[33:0]) : in_data.vel[i];
            s3_next.prev[i] = in_data.prev[i];
        end
        s3_next.hit_any   = |(below | above);
        s3_next.floor_hit = below[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

`include "particle_box_collision_step_assert.svh"

    `PBCS_ASSERT_NXT(a_floor_flag, aclk, aresetn, adv && in_valid && below[2], s3_reg.floor_hit && s3_reg.hit_any)
    `PBCS_ASSERT_NXT(a_no_hit, aclk, aresetn, adv && in_valid && (below == '0) && (above == '0), !s3_reg.hit_any && (s3_reg.pos == $past(in_data.pos)))
    `PBCS_ASSERT_NXT(a_hold_on_stall, aclk, aresetn, !adv, $stable(s3_reg) && $stable(s3_valid_reg))

endmodule

// ===== hw/rtl/pbcs_damp.sv =====
// ----------------------------------------------------------------------------
// Particle box collision step: damping and output stages
// Applies floor friction to X and Y velocity and forms the update flag.
// ----------------------------------------------------------------------------
module pbcs_damp import pbcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  pbcs_s3_t  in_data,
    output logic      out_valid,
    output pbcs_out_t out_data
);

    localparam logic signed [32:0] TOL_W  = 33'(TOL_LSB);
    localparam logic signed [16:0] DAMP_W = 17'(DAMP_Q16);

    logic                       s4_valid_reg;
    q16_t [NUM_AXES-1:0]        s4_pos_reg;
    q16_t [NUM_AXES-1:0]        s4_vel_reg;
    logic [1:0][48:0]           s4_prod_reg;
    logic [NUM_AXES-1:0]        s4_moved_reg;
    logic                       s4_hit_reg;
    logic                       s4_floor_reg;
    logic [1:0][48:0]           s4_prod_next;
    logic [NUM_AXES-1:0]        s4_moved_next;
    q16_t [NUM_AXES-1:0]        vel_fin;
    logic                       m_valid_reg;
    pbcs_out_t                  m_data_reg;
    pbcs_out_t                  m_data_next;

    always_comb begin
        logic signed [32:0] d;
        d = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            d = $signed({in_data.pos[i][31], in_data.pos[i]})
              - $signed({in_data.prev[i][31], in_data.prev[i]});
            s4_moved_next[i] = (d > TOL_W) || (d < -TOL_W);
        end
        for (int i = 0; i < 2; i++) begin
            s4_prod_next[i] = $signed(in_data.vel[i]) * DAMP_W;
        end
    end

    always_comb begin
        logic signed [48:0] sh;
        sh = '0;
        vel_fin = s4_vel_reg;
        for (int i = 0; i < 2; i++) begin
            sh = $signed(s4_prod_reg[i]) >>> PROD_SHIFT;
            if (s4_floor_reg) begin
                vel_fin[i] = sat32(sh[33:0]);
            end
        end
        m_data_next.new_pos_x    = s4_pos_reg[0];
        m_data_next.new_pos_y    = s4_pos_reg[1];
        m_data_next.new_pos_z    = s4_pos_reg[2];
        m_data_next.new_vel_x    = vel_fin[0];
        m_data_next.new_vel_y    = vel_fin[1];
        m_data_next.new_vel_z    = vel_fin[2];
        m_data_next.needs_update = s4_hit_reg || (|s4_moved_reg)
                                || (vel_fin[0] != '0) || (vel_fin[1] != '0)
                                || (vel_fin[2] != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= in_valid;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_pos_reg   <= in_data.pos;
            s4_vel_reg   <= in_data.vel;
            s4_prod_reg  <= s4_prod_next;
            s4_moved_reg <= s4_moved_next;
            s4_hit_reg   <= in_data.hit_any;
            s4_floor_reg <= in_data.floor_hit;
            m_data_reg   <= m_data_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

// ===== hw/rtl/particle_box_collision_step.sv =====
// ----------------------------------------------------------------------------
// Particle box collision step
// Integrates one particle per transaction and keeps it inside a box.
// ----------------------------------------------------------------------------
//   channel   ports                            payload
//   input     s_valid / s_ready / s_data       pbcs_in_t
//   result    m_valid / m_ready / m_data       pbcs_out_t
//   config    cfg_we / cfg_index / cfg_wdata   one register per write
//
// One transaction per cycle while the result channel is not stalled.
// The five register stages are integrate product, position sum, wall test,
// damping product and output register; the multipliers set the stage split.
// Reset (aresetn, synchronous) empties the pipeline and loads default registers.
// A stalled result freezes every stage, so s_ready falls with it.
// ----------------------------------------------------------------------------
module particle_box_collision_step import pbcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pbcs_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pbcs_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      adv;
    pbcs_cfg_t cfg;
    logic      s2_valid;
    pbcs_s2_t  s2_data;
    logic      s3_valid;
    pbcs_s3_t  s3_data;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    pbcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pbcs_integrate u_integrate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    pbcs_wall u_wall (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .cfg       (cfg),
        .out_valid (s3_valid),
        .out_data  (s3_data)
    );

    pbcs_damp u_damp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s3_valid),
        .in_data   (s3_data),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle box collision step: testbench
// Streams particles through the block with random idling on both channels,
// predicts each updated particle from the box registers and checks every
// result field by field, across default, extreme and random box settings.
// ----------------------------------------------------------------------------
module tb_top;
    import pbcs_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int PIPE_LAT       = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int ONE            = 65536;
    localparam int Q_SHIFT        = 16;
    localparam longint FLOOR_DAMP = 58982;
    localparam longint NEAR_LSB   = 7;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 250;
    localparam int NO_IDLE_PHASE  = 2;
    localparam int HOLD_PHASE     = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    pbcs_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    pbcs_out_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic idle_en;
    int   error_count;
    int   quiet_cycles;

    longint box_mid [3]  = '{0, 0, 0};
    longint box_half [3] = '{6553600, 13107200, 13107200};
    longint ball_radius  = 655360;
    longint bounce_gain  = 52429;

    pbcs_out_t stepped_particles [$];

    particle_box_collision_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic longint clamp_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint scale_q16(input longint v, input longint k);
        return clamp_q16((v * k) >>> Q_SHIFT);
    endfunction

    function automatic pbcs_out_t advance_particle(input pbcs_in_t pkt);
        longint    pos [3];
        longint    vel [3];
        longint    start [3];
        longint    lo_wall;
        longint    hi_wall;
        longint    moved;
        logic      bounced;
        logic      floor_hit;
        logic      fresh;
        int        a;
        pbcs_out_t res;
        start[0] = pkt.pos_x;
        start[1] = pkt.pos_y;
        start[2] = pkt.pos_z;
        vel[0]   = pkt.vel_x;
        vel[1]   = pkt.vel_y;
        vel[2]   = pkt.vel_z;
        bounced   = 1'b0;
        floor_hit = 1'b0;
        for (a = 0; a < 3; a++) begin
            pos[a] = clamp_q16(start[a] + ((vel[a] * longint'(pkt.time_step)) >>> Q_SHIFT));
        end
        // The low wall wins when the sphere overlaps both walls.
        for (a = 0; a < 3; a++) begin
            lo_wall = box_mid[a] - box_half[a];
            hi_wall = box_mid[a] + box_half[a];
            if (pos[a] - ball_radius < lo_wall) begin
                pos[a]  = clamp_q16(lo_wall + ball_radius);
                vel[a]  = scale_q16(vel[a], -bounce_gain);
                bounced = 1'b1;
                if (a == 2) begin
                    floor_hit = 1'b1;
                end
            end else if (pos[a] + ball_radius > hi_wall) begin
                pos[a]  = clamp_q16(hi_wall - ball_radius);
                vel[a]  = scale_q16(vel[a], -bounce_gain);
                bounced = 1'b1;
            end
        end
        if (floor_hit) begin
            vel[0] = scale_q16(vel[0], FLOOR_DAMP);
            vel[1] = scale_q16(vel[1], FLOOR_DAMP);
        end
        fresh = bounced;
        for (a = 0; a < 3; a++) begin
            moved = pos[a] - start[a];
            if (moved < 0) begin
                moved = -moved;
            end
            if (vel[a] != 0 || moved > NEAR_LSB) begin
                fresh = 1'b1;
            end
        end
        res.new_pos_x    = q16_t'(pos[0]);
        res.new_pos_y    = q16_t'(pos[1]);
        res.new_pos_z    = q16_t'(pos[2]);
        res.new_vel_x    = q16_t'(vel[0]);
        res.new_vel_y    = q16_t'(vel[1]);
        res.new_vel_z    = q16_t'(vel[2]);
        res.needs_update = fresh;
        return res;
    endfunction

    function automatic pbcs_in_t make_item(input int px, input int py, input int pz,
                                           input int vx, input int vy, input int vz,
                                           input int dt);
        pbcs_in_t pkt;
        pkt.pos_x     = px;
        pkt.pos_y     = py;
        pkt.pos_z     = pz;
        pkt.vel_x     = vx;
        pkt.vel_y     = vy;
        pkt.vel_z     = vz;
        pkt.time_step = dt[15:0];
        return pkt;
    endfunction

    function automatic logic [31:0] rand_coord(input int axis);
        longint      span;
        logic [63:0] pick;
        case ($urandom_range(0, 9))
            0: begin
                return $urandom();
            end
            1: begin
                return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            default: begin
                span = box_half[axis] + 2 * ball_radius + 64;
                pick = {$urandom(), $urandom()};
                return 32'(clamp_q16(box_mid[axis] + longint'(pick % (2 * span + 1)) - span));
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_velocity();
        case ($urandom_range(0, 9))
            0: begin
                return $urandom();
            end
            1: begin
                return 32'h0;
            end
            2: begin
                return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            default: begin
                return $signed($urandom()) >>> $urandom_range(6, 16);
            end
        endcase
    endfunction

    function automatic int rand_step();
        case ($urandom_range(0, 9))
            0: begin
                return 0;
            end
            1: begin
                return 16'hFFFF;
            end
            default: begin
                return $urandom_range(0, 65535);
            end
        endcase
    endfunction

    function automatic pbcs_in_t random_particle();
        return make_item(rand_coord(0), rand_coord(1), rand_coord(2),
                         rand_velocity(), rand_velocity(), rand_velocity(), rand_step());
    endfunction

    function automatic logic [31:0] rand_center();
        return $signed($urandom()) >>> $urandom_range(0, 12);
    endfunction

    // The unused top bit is filled at random; the block must ignore it.
    function automatic logic [31:0] rand_span(input int lo);
        logic [31:0] r;
        r     = $urandom() >> $urandom_range(lo, lo + 14);
        r[31] = $urandom_range(0, 1);
        return r;
    endfunction

    function automatic logic [31:0] rand_gain();
        logic [31:0] r;
        if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(65537, 131071);
        end else begin
            r = $urandom_range(0, 65536);
        end
        r[31:17] = 15'($urandom());
        return r;
    endfunction

    task automatic load_box(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] hx,
                            input logic [31:0] hy, input logic [31:0] hz,
                            input logic [31:0] rad, input logic [31:0] gain);
        logic [31:0]   vals [8];
        pbcs_cfg_idx_t idx;
        vals = '{cx, cy, cz, hx, hy, hz, rad, gain};
        for (int i = 0; i < 8; i++) begin
            idx = pbcs_cfg_idx_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (idx)
                CFG_BOX_CENTER_X, CFG_BOX_CENTER_Y, CFG_BOX_CENTER_Z: begin
                    box_mid[i - CFG_BOX_CENTER_X] = $signed(vals[i]);
                end
                CFG_HALF_EXTENT_X, CFG_HALF_EXTENT_Y, CFG_HALF_EXTENT_Z: begin
                    box_half[i - CFG_HALF_EXTENT_X] = longint'(vals[i][30:0]);
                end
                CFG_PARTICLE_RADIUS: begin
                    ball_radius = longint'(vals[i][30:0]);
                end
                CFG_RESTITUTION: begin
                    bounce_gain = longint'(vals[i][16:0]);
                end
                default: begin
                end
            endcase
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_particle(input pbcs_in_t pkt);
        while (idle_en && $urandom_range(0, 99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pkt;
        do @(posedge aclk); while (!s_ready);
        stepped_particles.push_back(advance_particle(pkt));
    endtask

    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (stepped_particles.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_LAT + 3) @(posedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("ERROR %0t: %s expected %h got %h", $realtime, what, want, got);
        end
    endtask

    task automatic test_default_box();
        push_particle(make_item(0, 0, 0, 0, 0, 0, 0));
        push_particle(make_item(ONE, -2 * ONE, 3 * ONE, 5 * ONE, -7 * ONE, 9 * ONE, 16'h8000));
        push_particle(make_item(-95 * ONE, 0, 0, -20 * ONE, 0, 0, 16'hFFFF));
        push_particle(make_item(95 * ONE, 0, 0, 20 * ONE, 0, 0, 16'hFFFF));
        push_particle(make_item(0, -195 * ONE, 0, 0, -20 * ONE, 0, 16'hFFFF));
        push_particle(make_item(0, 195 * ONE, 0, 0, 20 * ONE, 0, 16'hFFFF));
        push_particle(make_item(0, 0, 195 * ONE, 0, 0, 20 * ONE, 16'hFFFF));
        push_particle(make_item(0, 0, -195 * ONE, 3 * ONE, -4 * ONE, -20 * ONE, 16'h4000));
        push_particle(make_item(-95 * ONE, -195 * ONE, -195 * ONE, -ONE, -ONE, -ONE, 16'hFFFF));
        push_particle(make_item(-90 * ONE, 190 * ONE, -190 * ONE, 0, 0, 0, 0));
        push_particle(make_item(-90 * ONE - 1, 190 * ONE + 1, -190 * ONE - 1, 0, 0, 0, 0));
        push_particle(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
        push_particle(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 16'hFFFF));
        push_particle(make_item(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0));
        push_particle(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA));
    endtask

    task automatic test_box_extremes();
        settle_pipeline();
        load_box(0, 0, 0, 0, 0, 0, 0, 0);
        push_particle(make_item(0, 0, 0, 0, 0, 0, 0));
        push_particle(make_item(1, -1, 0, ONE, ONE, ONE, 0));
        push_particle(make_item(-1, 1, -1, -ONE, ONE, -ONE, 16'h5555));

        // A radius larger than the box puts every coordinate past one of the walls.
        settle_pipeline();
        load_box(0, 0, 0, ONE, ONE, ONE, 32'h7FFF_FFFF, 32'h0001_FFFF);
        push_particle(make_item(0, 0, 0, 0, 0, 0, 0));
        push_particle(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
        push_particle(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));

        settle_pipeline();
        load_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 32'hFFFF_0000);
        push_particle(make_item(32'h7FFF_FFFF, 32'h8000_0000, 0, ONE, -ONE, ONE, 16'hFFFF));
        push_particle(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
        push_particle(make_item(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1));
    endtask

    task automatic test_random_particles();
        for (int phase = 0; phase < PHASES; phase++) begin
            settle_pipeline();
            load_box(rand_center(), rand_center(), rand_center(), rand_span(1),
                     rand_span(1), rand_span(1), rand_span(6), rand_gain());
            idle_en <= (phase != NO_IDLE_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == HOLD_PHASE && n == PHASE_ITEMS / 2) begin
                    settle_pipeline();
                end
                push_particle(random_particle());
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_en || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge aclk) begin : check_results
        pbcs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stepped_particles.size() == 0) begin
                flag_mismatch("unexpected transaction, new_pos_x", 32'h0, m_data.new_pos_x);
            end else begin
                want = stepped_particles.pop_front();
                if (m_data.new_pos_x !== want.new_pos_x) begin
                    flag_mismatch("new_pos_x", want.new_pos_x, m_data.new_pos_x);
                end
                if (m_data.new_pos_y !== want.new_pos_y) begin
                    flag_mismatch("new_pos_y", want.new_pos_y, m_data.new_pos_y);
                end
                if (m_data.new_pos_z !== want.new_pos_z) begin
                    flag_mismatch("new_pos_z", want.new_pos_z, m_data.new_pos_z);
                end
                if (m_data.new_vel_x !== want.new_vel_x) begin
                    flag_mismatch("new_vel_x", want.new_vel_x, m_data.new_vel_x);
                end
                if (m_data.new_vel_y !== want.new_vel_y) begin
                    flag_mismatch("new_vel_y", want.new_vel_y, m_data.new_vel_y);
                end
                if (m_data.new_vel_z !== want.new_vel_z) begin
                    flag_mismatch("new_vel_z", want.new_vel_z, m_data.new_vel_z);
                end
                if (m_data.needs_update !== want.needs_update) begin
                    flag_mismatch("needs_update", want.needs_update, m_data.needs_update);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("particle_box_collision_step verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        error_count = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BOX_CENTER_X;
        cfg_wdata <= '0;
        idle_en   <= 1'b1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_box();
        test_box_extremes();
        test_random_particles();

        settle_pipeline();
        if (error_count == 0) begin
            $display("particle_box_collision_step verification clean");
        end else begin
            $display("particle_box_collision_step verification failed");
        end
        $finish;
    end

endmodule
